@@ rtl/aff_inv_pkg.sv @@
package aff_inv_pkg;

  // external field widths
  localparam int FIELD_W = 32;
  localparam int THR_W   = 32;

  // default number format
  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // singular threshold after reset, about 1e-5 in Q32.32
  localparam logic [THR_W-1:0] THR_RESET = 32'd42950;

  // divider lanes, one per linear coefficient of the inverse
  localparam int LANES  = 4;
  localparam int LANE_A = 0;
  localparam int LANE_B = 1;
  localparam int LANE_C = 2;
  localparam int LANE_D = 3;

endpackage

@@ rtl/aff_inv_in_if.sv @@
interface aff_inv_in_if;
  logic valid;
  logic ready;
  logic signed [aff_inv_pkg::FIELD_W-1:0] coef_a;
  logic signed [aff_inv_pkg::FIELD_W-1:0] coef_b;
  logic signed [aff_inv_pkg::FIELD_W-1:0] coef_c;
  logic signed [aff_inv_pkg::FIELD_W-1:0] coef_d;
  logic signed [aff_inv_pkg::FIELD_W-1:0] coef_e;
  logic signed [aff_inv_pkg::FIELD_W-1:0] coef_f;

  modport source (output valid, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
                  input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
                output ready);
endinterface

@@ rtl/aff_inv_out_if.sv @@
interface aff_inv_out_if;
  logic valid;
  logic ready;
  logic signed [aff_inv_pkg::FIELD_W-1:0] inv_a;
  logic signed [aff_inv_pkg::FIELD_W-1:0] inv_b;
  logic signed [aff_inv_pkg::FIELD_W-1:0] inv_c;
  logic signed [aff_inv_pkg::FIELD_W-1:0] inv_d;
  logic signed [aff_inv_pkg::FIELD_W-1:0] inv_e;
  logic signed [aff_inv_pkg::FIELD_W-1:0] inv_f;
  logic singular;
  logic saturated;

  modport source (output valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, singular,
                  saturated, input ready);
  modport sink (input valid, inv_a, inv_b, inv_c, inv_d, inv_e, inv_f, singular,
                saturated, output ready);
endinterface

@@ rtl/aff_inv_det.sv @@
module aff_inv_det #(
  parameter int CW = aff_inv_pkg::COEF_WIDTH,
  parameter int MW = 2 * aff_inv_pkg::COEF_WIDTH
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [CW-1:0]                      in_a,
  input  logic signed [CW-1:0]                      in_b,
  input  logic signed [CW-1:0]                      in_c,
  input  logic signed [CW-1:0]                      in_d,
  input  logic signed [CW-1:0]                      in_e,
  input  logic signed [CW-1:0]                      in_f,
  input  logic [aff_inv_pkg::THR_W-1:0]             thr,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [MW-1:0]                             out_den,
  output logic [aff_inv_pkg::LANES-1:0][CW-1:0]     out_nm,
  output logic [aff_inv_pkg::LANES-1:0]             out_sgn,
  output logic                                      out_sing,
  output logic signed [CW-1:0]                      out_e,
  output logic signed [CW-1:0]                      out_f
);

  localparam int L = aff_inv_pkg::LANES;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  // stage 1: input register
  logic signed [CW-1:0] a1_r, b1_r, c1_r, d1_r, e1_r, f1_r;
  // stage 2: products and numerator magnitudes
  logic signed [MW-1:0] p1_r, p2_r;
  logic [CW-1:0]        nm2_r [L];
  logic [L-1:0]         nn2_r;
  logic signed [CW-1:0] e2_r, f2_r;
  // stage 3: determinant magnitude, signs, singular test
  logic [MW-1:0]        den3_r;
  logic [CW-1:0]        nm3_r [L];
  logic [L-1:0]         sgn3_r;
  logic                 sing3_r;
  logic signed [CW-1:0] e3_r, f3_r;

  logic [CW-1:0] num [L];
  logic [CW-1:0] nmag [L];
  logic [L-1:0]  nneg;
  logic signed [MW:0] dif, dabs;
  logic          dneg;
  logic [MW-1:0] dmag;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // lane numerators: inv_a from d, inv_b from -b, inv_c from -c, inv_d from a
  always_comb begin
    num[aff_inv_pkg::LANE_A]  = d1_r;
    nneg[aff_inv_pkg::LANE_A] = d1_r[CW-1];
    num[aff_inv_pkg::LANE_B]  = b1_r;
    nneg[aff_inv_pkg::LANE_B] = !b1_r[CW-1] && (|b1_r);
    num[aff_inv_pkg::LANE_C]  = c1_r;
    nneg[aff_inv_pkg::LANE_C] = !c1_r[CW-1] && (|c1_r);
    num[aff_inv_pkg::LANE_D]  = a1_r;
    nneg[aff_inv_pkg::LANE_D] = a1_r[CW-1];
    for (int l = 0; l < L; l++) begin
      nmag[l] = num[l][CW-1] ? (~num[l] + 1'b1) : num[l];
    end
  end

  always_comb begin
    dif  = (MW+1)'(p1_r) - (MW+1)'(p2_r);
    dneg = dif[MW];
    dabs = dneg ? -dif : dif;
    dmag = dabs[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      a1_r <= in_a;
      b1_r <= in_b;
      c1_r <= in_c;
      d1_r <= in_d;
      e1_r <= in_e;
      f1_r <= in_f;
    end
    if (adv2) begin
      p1_r  <= MW'(a1_r) * MW'(d1_r);
      p2_r  <= MW'(b1_r) * MW'(c1_r);
      nm2_r <= nmag;
      nn2_r <= nneg;
      e2_r  <= e1_r;
      f2_r  <= f1_r;
    end
    if (adv3) begin
      den3_r  <= dmag;
      nm3_r   <= nm2_r;
      sgn3_r  <= nn2_r ^ {L{dneg}};
      sing3_r <= dmag <= MW'(thr);
      e3_r    <= e2_r;
      f3_r    <= f2_r;
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      out_nm[l] = nm3_r[l];
    end
  end

  assign out_valid = v3_r;
  assign out_den   = den3_r;
  assign out_sgn   = sgn3_r;
  assign out_sing  = sing3_r;
  assign out_e     = e3_r;
  assign out_f     = f3_r;

endmodule

@@ rtl/aff_inv_div.sv @@
module aff_inv_div #(
  parameter int CW     = aff_inv_pkg::COEF_WIDTH,
  parameter int FB     = aff_inv_pkg::FRAC_BITS,
  parameter int MW     = 2 * aff_inv_pkg::COEF_WIDTH,
  parameter int SIDE_W = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [MW-1:0]                         in_den,
  input  logic [aff_inv_pkg::LANES-1:0][CW-1:0] in_nm,
  input  logic [aff_inv_pkg::LANES-1:0]         in_sgn,
  input  logic [SIDE_W-1:0]                     in_side,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [aff_inv_pkg::LANES-1:0][CW-1:0] out_q,
  output logic [aff_inv_pkg::LANES-1:0]         out_ovf,
  output logic [aff_inv_pkg::LANES-1:0]         out_sgn,
  output logic [SIDE_W-1:0]                     out_side
);

  localparam int L    = aff_inv_pkg::LANES;
  localparam int NS   = CW + 1;       // setup stage plus one stage per quotient bit
  localparam int NW   = CW + 2 * FB;  // dividend nm << 2*FB
  localparam int CMPW = MW + 2 * FB;

  logic [NS-1:0]     v_r;
  logic [NS:0]       adv;
  logic [MW-1:0]     den_r  [NS];
  logic [MW-1:0]     rem_r  [NS][L];
  logic [CW-1:0]     q_r    [NS][L];
  logic [CW-1:0]     lo_r   [NS][L];
  logic [L-1:0]      ovf_r  [NS];
  logic [L-1:0]      sgn_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];

  assign adv[NS]  = out_ready;
  assign in_ready = adv[0];

  // setup: high part of the dividend must stay below the divisor,
  // otherwise the quotient does not fit and the lane saturates
  logic [NW-1:0]     nfull [L];
  logic [CMPW-1:0]   hx    [L];
  logic [MW-1:0]     rem0  [L];
  logic [CW-1:0]     lo0   [L];
  logic [L-1:0]      ovf0;

  always_comb begin
    for (int l = 0; l < L; l++) begin
      nfull[l] = {in_nm[l], {(2*FB){1'b0}}};
      hx[l]    = CMPW'(nfull[l][NW-1:CW]);
      ovf0[l]  = hx[l] >= CMPW'(in_den);
      rem0[l]  = hx[l][MW-1:0];
      lo0[l]   = nfull[l][CW-1:0];
    end
  end

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      assign adv[k] = !v_r[k] || adv[k+1];

      if (k == 0) begin : g_setup
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[k] <= 1'b0;
          end else if (adv[k]) begin
            v_r[k] <= in_valid;
          end
        end

        always_ff @(posedge clk) begin
          if (adv[k]) begin
            den_r[k]  <= in_den;
            rem_r[k]  <= rem0;
            lo_r[k]   <= lo0;
            ovf_r[k]  <= ovf0;
            sgn_r[k]  <= in_sgn;
            side_r[k] <= in_side;
            for (int l = 0; l < L; l++) begin
              q_r[k][l] <= '0;
            end
          end
        end
      end else begin : g_iter
        logic [MW:0]   t   [L];
        logic [MW:0]   sub [L];
        logic [L-1:0]  ge;
        logic [MW-1:0] rn  [L];

        // one restoring step: shift in the next dividend bit, subtract if it fits
        always_comb begin
          for (int l = 0; l < L; l++) begin
            t[l]   = {rem_r[k-1][l], lo_r[k-1][l][CW-1]};
            sub[l] = t[l] - {1'b0, den_r[k-1]};
            ge[l]  = t[l] >= {1'b0, den_r[k-1]};
            rn[l]  = ge[l] ? sub[l][MW-1:0] : t[l][MW-1:0];
          end
        end

        always_ff @(posedge clk) begin
          if (!rst_n) begin
            v_r[k] <= 1'b0;
          end else if (adv[k]) begin
            v_r[k] <= v_r[k-1];
          end
        end

        always_ff @(posedge clk) begin
          if (adv[k]) begin
            den_r[k]  <= den_r[k-1];
            ovf_r[k]  <= ovf_r[k-1];
            sgn_r[k]  <= sgn_r[k-1];
            side_r[k] <= side_r[k-1];
            for (int l = 0; l < L; l++) begin
              rem_r[k][l] <= rn[l];
              q_r[k][l]   <= {q_r[k-1][l][CW-2:0], ge[l]};
              lo_r[k][l]  <= {lo_r[k-1][l][CW-2:0], 1'b0};
            end
          end
        end
      end
    end
  endgenerate

  always_comb begin
    for (int l = 0; l < L; l++) begin
      out_q[l] = q_r[NS-1][l];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_ovf   = ovf_r[NS-1];
  assign out_sgn   = sgn_r[NS-1];
  assign out_side  = side_r[NS-1];

endmodule

@@ rtl/aff_inv_trans.sv @@
module aff_inv_trans #(
  parameter int CW = aff_inv_pkg::COEF_WIDTH,
  parameter int FB = aff_inv_pkg::FRAC_BITS,
  parameter int MW = 2 * aff_inv_pkg::COEF_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [aff_inv_pkg::LANES-1:0][CW-1:0] in_q,
  input  logic [aff_inv_pkg::LANES-1:0]         in_ovf,
  input  logic [aff_inv_pkg::LANES-1:0]         in_sgn,
  input  logic                                  in_sing,
  input  logic signed [CW-1:0]                  in_e,
  input  logic signed [CW-1:0]                  in_f,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [CW-1:0]                  out_a,
  output logic signed [CW-1:0]                  out_b,
  output logic signed [CW-1:0]                  out_c,
  output logic signed [CW-1:0]                  out_d,
  output logic signed [CW-1:0]                  out_e,
  output logic signed [CW-1:0]                  out_f,
  output logic                                  out_sing,
  output logic                                  out_sat
);

  localparam int L  = aff_inv_pkg::LANES;
  localparam int XW = MW + 2;
  localparam logic [CW-1:0] HI_C    = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] LO_C    = {1'b1, {(CW-1){1'b0}}};
  localparam logic          ONE_SAT = (FB >= CW - 1);
  localparam logic [CW-1:0] ONE_VAL = (FB >= CW - 1) ? HI_C : (CW'(1) << FB);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  // stage 1: signed, clipped linear part
  logic signed [CW-1:0] r1_r [L];
  logic                 sat1_r, sing1_r;
  logic signed [CW-1:0] e1_r, f1_r;
  // stage 2: translation products
  logic signed [MW-1:0] m2_r [L];
  logic signed [CW-1:0] r2_r [L];
  logic                 sat2_r, sing2_r;
  // stage 3: output register
  logic signed [CW-1:0] r3_r [L];
  logic signed [CW-1:0] t3_r [2];
  logic                 sat3_r, sing3_r;

  logic [CW-1:0] cl [L];
  logic [L-1:0]  cs;
  logic signed [XW-1:0] xs [2];
  logic signed [XW-1:0] sh [2];
  logic [CW-1:0] tv [2];
  logic [1:0]    ts;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // apply quotient sign and clip; singular matrices give the identity
  always_comb begin
    for (int l = 0; l < L; l++) begin
      cs[l] = 1'b0;
      if (in_ovf[l]) begin
        cl[l] = in_sgn[l] ? LO_C : HI_C;
        cs[l] = 1'b1;
      end else if (!in_sgn[l]) begin
        cl[l] = in_q[l][CW-1] ? HI_C : in_q[l];
        cs[l] = in_q[l][CW-1];
      end else if (in_q[l][CW-1] && (|in_q[l][CW-2:0])) begin
        cl[l] = LO_C;
        cs[l] = 1'b1;
      end else begin
        cl[l] = ~in_q[l] + 1'b1;
      end
    end
    if (in_sing) begin
      cl[aff_inv_pkg::LANE_A] = ONE_VAL;
      cl[aff_inv_pkg::LANE_B] = '0;
      cl[aff_inv_pkg::LANE_C] = '0;
      cl[aff_inv_pkg::LANE_D] = ONE_VAL;
    end
  end

  // floor(-(p + r) / 2^FB) and clip
  always_comb begin
    xs[0] = -(XW'(m2_r[0]) + XW'(m2_r[1]));
    xs[1] = -(XW'(m2_r[2]) + XW'(m2_r[3]));
    for (int j = 0; j < 2; j++) begin
      sh[j] = xs[j] >>> FB;
      if ((&sh[j][XW-1:CW-1]) || !(|sh[j][XW-1:CW-1])) begin
        tv[j] = sh[j][CW-1:0];
        ts[j] = 1'b0;
      end else begin
        tv[j] = sh[j][XW-1] ? LO_C : HI_C;
        ts[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int l = 0; l < L; l++) begin
        r1_r[l] <= cl[l];
      end
      sat1_r  <= in_sing ? ONE_SAT : (|cs);
      sing1_r <= in_sing;
      e1_r    <= in_e;
      f1_r    <= in_f;
    end
    if (adv2) begin
      m2_r[0] <= MW'(e1_r) * MW'(r1_r[aff_inv_pkg::LANE_A]);
      m2_r[1] <= MW'(f1_r) * MW'(r1_r[aff_inv_pkg::LANE_C]);
      m2_r[2] <= MW'(e1_r) * MW'(r1_r[aff_inv_pkg::LANE_B]);
      m2_r[3] <= MW'(f1_r) * MW'(r1_r[aff_inv_pkg::LANE_D]);
      r2_r    <= r1_r;
      sat2_r  <= sat1_r;
      sing2_r <= sing1_r;
    end
    if (adv3) begin
      r3_r    <= r2_r;
      t3_r[0] <= sing2_r ? '0 : tv[0];
      t3_r[1] <= sing2_r ? '0 : tv[1];
      sat3_r  <= sat2_r || (!sing2_r && (|ts));
      sing3_r <= sing2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_a     = r3_r[aff_inv_pkg::LANE_A];
  assign out_b     = r3_r[aff_inv_pkg::LANE_B];
  assign out_c     = r3_r[aff_inv_pkg::LANE_C];
  assign out_d     = r3_r[aff_inv_pkg::LANE_D];
  assign out_e     = t3_r[0];
  assign out_f     = t3_r[1];
  assign out_sing  = sing3_r;
  assign out_sat   = sat3_r;

endmodule

@@ rtl/affine_2d_matrix_inverse_top.sv @@
// throughput: one matrix per cycle while out_ch.ready is high; the restoring divider
//   spends one pipeline stage per quotient bit (COEF_WIDTH stages), four lanes side by side,
//   so its depth sets latency
// every stage stalls only while the stage after it is full
// reset (rst_n low, synchronous): pipeline emptied, threshold back to 42950
module affine_2d_matrix_inverse_top #(
  parameter int COEF_WIDTH = aff_inv_pkg::COEF_WIDTH,
  parameter int FRAC_BITS  = aff_inv_pkg::FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  aff_inv_in_if.sink                       in_ch,
  aff_inv_out_if.source                    out_ch,
  input  logic                             cfg_we,
  input  logic [aff_inv_pkg::THR_W-1:0]    cfg_wdata
);

  localparam int CW = COEF_WIDTH;
  localparam int MW = 2 * COEF_WIDTH;
  localparam int FW = aff_inv_pkg::FIELD_W;
  localparam int L  = aff_inv_pkg::LANES;
  // side data that rides along the divider: singular flag, e, f
  localparam int SIDE_W = 1 + 2 * CW;

  // singular threshold register
  logic [aff_inv_pkg::THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= aff_inv_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // only the low COEF_WIDTH bits of each coefficient count, taken as signed
  logic signed [CW-1:0] a_in, b_in, c_in, d_in, e_in, f_in;
  assign a_in = in_ch.coef_a[CW-1:0];
  assign b_in = in_ch.coef_b[CW-1:0];
  assign c_in = in_ch.coef_c[CW-1:0];
  assign d_in = in_ch.coef_d[CW-1:0];
  assign e_in = in_ch.coef_e[CW-1:0];
  assign f_in = in_ch.coef_f[CW-1:0];

  // determinant front end -> divider
  logic                   dt_valid, dt_ready;
  logic [MW-1:0]          dt_den;
  logic [L-1:0][CW-1:0]   dt_nm;
  logic [L-1:0]           dt_sgn;
  logic                   dt_sing;
  logic signed [CW-1:0]   dt_e, dt_f;

  aff_inv_det #(
    .CW (CW),
    .MW (MW)
  ) u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_a      (a_in),
    .in_b      (b_in),
    .in_c      (c_in),
    .in_d      (d_in),
    .in_e      (e_in),
    .in_f      (f_in),
    .thr       (thr_r),
    .out_valid (dt_valid),
    .out_ready (dt_ready),
    .out_den   (dt_den),
    .out_nm    (dt_nm),
    .out_sgn   (dt_sgn),
    .out_sing  (dt_sing),
    .out_e     (dt_e),
    .out_f     (dt_f)
  );

  // divider -> clip and translation back end
  logic                   dv_valid, dv_ready;
  logic [L-1:0][CW-1:0]   dv_q;
  logic [L-1:0]           dv_ovf;
  logic [L-1:0]           dv_sgn;
  logic [SIDE_W-1:0]      dv_side;

  aff_inv_div #(
    .CW     (CW),
    .FB     (FRAC_BITS),
    .MW     (MW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dt_valid),
    .in_ready  (dt_ready),
    .in_den    (dt_den),
    .in_nm     (dt_nm),
    .in_sgn    (dt_sgn),
    .in_side   ({dt_sing, dt_e, dt_f}),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_q     (dv_q),
    .out_ovf   (dv_ovf),
    .out_sgn   (dv_sgn),
    .out_side  (dv_side)
  );

  logic signed [CW-1:0] res_a, res_b, res_c, res_d, res_e, res_f;
  logic                 res_sing, res_sat;

  aff_inv_trans #(
    .CW (CW),
    .FB (FRAC_BITS),
    .MW (MW)
  ) u_trans (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_q      (dv_q),
    .in_ovf    (dv_ovf),
    .in_sgn    (dv_sgn),
    .in_sing   (dv_side[SIDE_W-1]),
    .in_e      (dv_side[2*CW-1:CW]),
    .in_f      (dv_side[CW-1:0]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_a     (res_a),
    .out_b     (res_b),
    .out_c     (res_c),
    .out_d     (res_d),
    .out_e     (res_e),
    .out_f     (res_f),
    .out_sing  (res_sing),
    .out_sat   (res_sat)
  );

  // results sign extended back to the field width
  assign out_ch.inv_a     = FW'(res_a);
  assign out_ch.inv_b     = FW'(res_b);
  assign out_ch.inv_c     = FW'(res_c);
  assign out_ch.inv_d     = FW'(res_d);
  assign out_ch.inv_e     = FW'(res_e);
  assign out_ch.inv_f     = FW'(res_f);
  assign out_ch.singular  = res_sing;
  assign out_ch.saturated = res_sat;

`ifndef SYNTHESIS
  localparam logic          ONE_SAT = (FRAC_BITS >= COEF_WIDTH - 1);
  localparam logic [FW-1:0] ONE_X   = (FRAC_BITS >= COEF_WIDTH - 1) ?
                                      FW'((64'd1 << (COEF_WIDTH - 1)) - 64'd1) :
                                      FW'(64'd1 << FRAC_BITS);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with an empty output stage");

  a_singular_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |->
      out_ch.inv_b == '0 && out_ch.inv_c == '0 && out_ch.inv_e == '0 && out_ch.inv_f == '0)
    else $error("singular transaction with nonzero off-diagonal or translation");

  a_singular_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |->
      out_ch.inv_a == ONE_X && out_ch.inv_d == ONE_X && out_ch.saturated == ONE_SAT)
    else $error("singular transaction without identity diagonal");
`endif

endmodule
